FILE: hw/rtl/rvaa_pkg.sv
// shared constants and the arctangent table for the axis rotation pipeline
`default_nettype none
package rvaa_pkg;

	// cordic depth and the width of a step index
	localparam int unsigned CORDIC_STEPS = 16;
	localparam int unsigned STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	// cordic datapath width, arctangent width (q.30)
	localparam int unsigned CW = 34;
	localparam int unsigned ATAN_W = 31;
	localparam logic signed [CW-1:0] CORDIC_X0 = CW'(64'd1 << 30);

	// angle clamp, q3.12
	localparam int ANGLE_LIMIT = 12868;

	// divider: denominator width, quotient bits, fraction bits of the quotient
	localparam int unsigned E_W = 38;
	localparam int unsigned DIV_BITS = 48;
	localparam int unsigned QF = 15;

	// atan(2^-i) in q.30, rounded
	function automatic logic [ATAN_W-1:0] atan_q30(input logic [4:0] idx);
		logic [ATAN_W-1:0] r;
		case (idx)
			5'd0: r = 31'd843314857;
			5'd1: r = 31'd497837829;
			5'd2: r = 31'd263043837;
			5'd3: r = 31'd133525159;
			5'd4: r = 31'd67021687;
			5'd5: r = 31'd33543516;
			5'd6: r = 31'd16775851;
			5'd7: r = 31'd8388437;
			5'd8: r = 31'd4194283;
			5'd9: r = 31'd2097149;
			5'd10: r = 31'd1048576;
			5'd11: r = 31'd524288;
			5'd12: r = 31'd262144;
			5'd13: r = 31'd131072;
			5'd14: r = 31'd65536;
			5'd15: r = 31'd32768;
			5'd16: r = 31'd16384;
			5'd17: r = 31'd8192;
			5'd18: r = 31'd4096;
			5'd19: r = 31'd2048;
			5'd20: r = 31'd1024;
			5'd21: r = 31'd512;
			5'd22: r = 31'd256;
			5'd23: r = 31'd128;
			5'd24: r = 31'd64;
			5'd25: r = 31'd32;
			5'd26: r = 31'd16;
			5'd27: r = 31'd8;
			5'd28: r = 31'd4;
			5'd29: r = 31'd2;
			5'd30: r = 31'd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/rvaa_cordic_cell.sv
// one rotation-mode cordic step, registered
`default_nettype none
module rvaa_cordic_cell (
	input logic clk,
	input logic [rvaa_pkg::STEP_W-1:0] step,
	input logic signed [rvaa_pkg::CW-1:0] x_in,
	input logic signed [rvaa_pkg::CW-1:0] y_in,
	input logic signed [rvaa_pkg::CW-1:0] z_in,
	output logic signed [rvaa_pkg::CW-1:0] x_q,
	output logic signed [rvaa_pkg::CW-1:0] y_q,
	output logic signed [rvaa_pkg::CW-1:0] z_q
);

	logic signed [rvaa_pkg::CW-1:0] dx;
	logic signed [rvaa_pkg::CW-1:0] dy;
	logic signed [rvaa_pkg::CW-1:0] da;

	always_comb begin
		dx = y_in >>> step;
		dy = x_in >>> step;
		da = signed'(rvaa_pkg::CW'(rvaa_pkg::atan_q30(5'(step))));
	end

	always_ff @(posedge clk) begin
		if (z_in >= 0) begin
			x_q <= x_in - dx;
			y_q <= y_in + dy;
			z_q <= z_in - da;
		end else begin
			x_q <= x_in + dx;
			y_q <= y_in - dy;
			z_q <= z_in + da;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/rvaa_div_cell.sv
// one restoring division step, one quotient bit, registered
`default_nettype none
module rvaa_div_cell (
	input logic clk,
	input logic [rvaa_pkg::E_W-1:0] divisor,
	input logic [rvaa_pkg::E_W-1:0] rem_in,
	input logic [rvaa_pkg::DIV_BITS-1:0] dq_in,
	output logic [rvaa_pkg::E_W-1:0] rem_q,
	output logic [rvaa_pkg::DIV_BITS-1:0] dq_q
);

	logic [rvaa_pkg::E_W:0] trial;
	logic [rvaa_pkg::E_W:0] diff;
	logic fits;

	// dividend bits leave at the top of dq, quotient bits enter at the bottom
	always_comb begin
		trial = {rem_in, dq_in[rvaa_pkg::DIV_BITS-1]};
		diff = trial - {1'b0, divisor};
		fits = trial >= {1'b0, divisor};
	end

	always_ff @(posedge clk) begin
		rem_q <= fits ? diff[rvaa_pkg::E_W-1:0] : trial[rvaa_pkg::E_W-1:0];
		dq_q <= {dq_in[rvaa_pkg::DIV_BITS-2:0], fits};
	end

endmodule
`default_nettype wire

FILE: hw/rtl/rotate_vector_about_axis_top.sv
// rodrigues rotation of a q16.16 vector about a q2.14 axis by a q3.12 angle
// a beat passes the cordic cells, four multiply stages, the divider cells and the output registers
// throughput: one beat per cycle, set by the cordic cells, four multiply stages and the
// one-bit-per-cell divider chain; busy is never raised
// the receiver cannot stall: done is high for exactly one cycle per beat
// reset: arst_n clears only the valid bits of the pipeline, payload registers are not reset
`default_nettype none
module rotate_vector_about_axis_top (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic signed [15:0] axis_x,
	input logic signed [15:0] axis_y,
	input logic signed [15:0] axis_z,
	input logic signed [31:0] vec_x,
	input logic signed [31:0] vec_y,
	input logic signed [31:0] vec_z,
	input logic signed [14:0] turn_angle,
	output logic done,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic saturated
);

	localparam int unsigned NS = rvaa_pkg::CORDIC_STEPS;
	localparam int unsigned CW = rvaa_pkg::CW;
	localparam int unsigned DB = rvaa_pkg::DIV_BITS;
	localparam int unsigned E_W = rvaa_pkg::E_W;
	localparam int unsigned QF = rvaa_pkg::QF;
	localparam int unsigned LOWB = DB - QF;

	// internal widths, sized from the worst-case magnitudes
	localparam int unsigned CS_W = 18;	// c and s, q.15
	localparam int unsigned PF_W = 50;	// a x v, q.30
	localparam int unsigned PS_W = 35;	// a x v, q.16
	localparam int unsigned A2F_W = 34;	// |a|^2, q.28
	localparam int unsigned A2_W = 19;	// |a|^2, q.14
	localparam int unsigned WF_W = 53;	// c*v + s*p, q.31
	localparam int unsigned W_W = 37;	// w, q.16
	localparam int unsigned SQ_W = 34;	// c^2 and s^2
	localparam int unsigned XF_W = 55;	// a x w, q.30
	localparam int unsigned X_W = 40;	// a x w, q.16
	localparam int unsigned EP_W = 56;	// s^2 * |a|^2
	localparam int unsigned N_W = 60;	// 2*s*x
	localparam int unsigned O_W = 50;	// v + increment before clamping
	localparam int unsigned LAT = NS + DB + 5;

	localparam int NX [0:2] = '{1, 2, 0};
	localparam int NY [0:2] = '{2, 0, 1};

	localparam logic signed [O_W-1:0] O_MAX = O_W'(64'sh7FFF_FFFF);
	localparam logic signed [O_W-1:0] O_MIN = -O_MAX - O_W'(1);

	// no back-pressure anywhere: a beat can enter every cycle
	assign busy = 1'b0;

	// ---------------------------------------------------------------
	// cordic chain: half angle in q.30, gain cancels in s/c
	// ---------------------------------------------------------------
	logic signed [14:0] ang_c;
	logic signed [CW-1:0] cx [0:NS];
	logic signed [CW-1:0] cy [0:NS];
	logic signed [CW-1:0] cz [0:NS];
	logic signed [15:0] ac [0:NS][0:2];
	logic signed [31:0] vc [0:NS][0:2];
	logic vld_c [0:NS];

	always_comb begin
		// clamp the angle to plus or minus pi
		if (turn_angle > rvaa_pkg::ANGLE_LIMIT) begin
			ang_c = 15'(rvaa_pkg::ANGLE_LIMIT);
		end else if (turn_angle < -rvaa_pkg::ANGLE_LIMIT) begin
			ang_c = 15'(-rvaa_pkg::ANGLE_LIMIT);
		end else begin
			ang_c = turn_angle;
		end
		cx[0] = rvaa_pkg::CORDIC_X0;
		cy[0] = '0;
		// q3.12 angle times 2^17 is the half angle in q.30
		cz[0] = CW'(ang_c) <<< 17;
		ac[0][0] = axis_x;
		ac[0][1] = axis_y;
		ac[0][2] = axis_z;
		vc[0][0] = vec_x;
		vc[0][1] = vec_y;
		vc[0][2] = vec_z;
		vld_c[0] = start & ~busy;
	end

	genvar k, ln;
	generate
		for (k = 0; k < NS; k++) begin : g_cordic
			rvaa_cordic_cell u_cell (
				.clk(clk),
				.step(rvaa_pkg::STEP_W'(k)),
				.x_in(cx[k]),
				.y_in(cy[k]),
				.z_in(cz[k]),
				.x_q(cx[k+1]),
				.y_q(cy[k+1]),
				.z_q(cz[k+1])
			);
		end
	endgenerate

	// axis and vector ride alongside the cordic cells
	always_ff @(posedge clk) begin
		for (int i = 0; i < NS; i++) begin
			for (int j = 0; j < 3; j++) begin
				ac[i+1][j] <= ac[i][j];
				vc[i+1][j] <= vc[i][j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NS; i++) vld_c[i] <= 1'b0;
		end else begin
			for (int i = 0; i < NS; i++) vld_c[i+1] <= vld_c[i];
		end
	end

	// ---------------------------------------------------------------
	// stage 1: c and s, tangent limit, a x v, |a|^2
	// ---------------------------------------------------------------
	logic signed [CS_W-1:0] c0;
	logic signed [CS_W-1:0] s0;
	logic [CS_W-1:0] abs_s;
	logic [CS_W-1:0] lim;
	logic tan_bad;
	logic signed [CS_W-1:0] c_fix;
	logic signed [PF_W-1:0] pf [0:2];
	logic signed [31:0] sq [0:2];
	logic [A2F_W-1:0] a2f;

	logic signed [CS_W-1:0] c_s1;
	logic signed [CS_W-1:0] s_s1;
	logic sat_s1;
	logic signed [PS_W-1:0] p_s1 [0:2];
	logic [A2_W-1:0] a2_s1;
	logic signed [15:0] a_s1 [0:2];
	logic signed [31:0] v_s1 [0:2];
	logic vld_s1;

	always_comb begin
		c0 = cx[NS][15 +: CS_W];
		s0 = cy[NS][15 +: CS_W];
		abs_s = s0[CS_W-1] ? unsigned'(-s0) : unsigned'(s0);
		lim = abs_s >> 12;
		// tangent above about 4096 or c not positive: pin c to |s|/4096, at least one
		tan_bad = (c0 <= 0) || (c0 < signed'(lim));
		if (tan_bad) begin
			c_fix = (lim != '0) ? signed'(lim) : CS_W'(1);
		end else begin
			c_fix = c0;
		end
		for (int i = 0; i < 3; i++) begin
			pf[i] = PF_W'(ac[NS][NX[i]]) * PF_W'(vc[NS][NY[i]])
				- PF_W'(ac[NS][NY[i]]) * PF_W'(vc[NS][NX[i]]);
			sq[i] = ac[NS][i] * ac[NS][i];
		end
		a2f = A2F_W'(unsigned'(sq[0])) + A2F_W'(unsigned'(sq[1]))
			+ A2F_W'(unsigned'(sq[2]));
	end

	always_ff @(posedge clk) begin
		c_s1 <= c_fix;
		s_s1 <= s0;
		sat_s1 <= tan_bad;
		for (int i = 0; i < 3; i++) begin
			p_s1[i] <= PS_W'(pf[i] >>> 14);
			a_s1[i] <= ac[NS][i];
			v_s1[i] <= vc[NS][i];
		end
		a2_s1 <= a2f[14 +: A2_W];
	end

	// ---------------------------------------------------------------
	// stage 2: w = c*v + s*p, c^2, s^2
	// ---------------------------------------------------------------
	logic signed [WF_W-1:0] wf [0:2];
	logic signed [2*CS_W-1:0] ccf;
	logic signed [2*CS_W-1:0] ssf;

	logic signed [W_W-1:0] w_s2 [0:2];
	logic [SQ_W-1:0] cc_s2;
	logic [SQ_W-1:0] ss_s2;
	logic [A2_W-1:0] a2_s2;
	logic signed [CS_W-1:0] s_s2;
	logic sat_s2;
	logic signed [15:0] a_s2 [0:2];
	logic signed [31:0] v_s2 [0:2];
	logic vld_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wf[i] = WF_W'(c_s1) * WF_W'(v_s1[i]) + WF_W'(s_s1) * WF_W'(p_s1[i]);
		end
		ccf = c_s1 * c_s1;
		ssf = s_s1 * s_s1;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			w_s2[i] <= W_W'(wf[i] >>> 15);
			a_s2[i] <= a_s1[i];
			v_s2[i] <= v_s1[i];
		end
		cc_s2 <= ccf[SQ_W-1:0];
		ss_s2 <= ssf[SQ_W-1:0];
		a2_s2 <= a2_s1;
		s_s2 <= s_s1;
		sat_s2 <= sat_s1;
	end

	// ---------------------------------------------------------------
	// stage 3: x = a x w, denominator e = c^2 + s^2*|a|^2
	// ---------------------------------------------------------------
	logic signed [XF_W-1:0] xf [0:2];
	logic [EP_W-1:0] epf;
	logic [EP_W-1:0] ef;

	logic signed [X_W-1:0] x_s3 [0:2];
	logic [E_W-1:0] e_s3;
	logic signed [CS_W-1:0] s_s3;
	logic sat_s3;
	logic signed [31:0] v_s3 [0:2];
	logic vld_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			xf[i] = XF_W'(a_s2[NX[i]]) * XF_W'(w_s2[NY[i]])
				- XF_W'(a_s2[NY[i]]) * XF_W'(w_s2[NX[i]]);
		end
		epf = EP_W'(ss_s2) * EP_W'(a2_s2);
		ef = EP_W'(cc_s2) + (epf >> 14);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			x_s3[i] <= X_W'(xf[i] >>> 14);
			v_s3[i] <= v_s2[i];
		end
		e_s3 <= ef[E_W-1:0];
		s_s3 <= s_s2;
		sat_s3 <= sat_s2;
	end

	// ---------------------------------------------------------------
	// stage 4: numerator n = 2*s*x, split into sign and magnitude
	// ---------------------------------------------------------------
	logic signed [N_W-1:0] nf [0:2];

	logic [N_W-1:0] mag_s4 [0:2];
	logic neg_s4 [0:2];
	logic [E_W-1:0] e_s4;
	logic sat_s4;
	logic signed [31:0] v_s4 [0:2];
	logic vld_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nf[i] = (N_W'(s_s3) * N_W'(x_s3[i])) <<< 1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mag_s4[i] <= nf[i][N_W-1] ? unsigned'(-nf[i]) : unsigned'(nf[i]);
			neg_s4[i] <= nf[i][N_W-1];
			v_s4[i] <= v_s3[i];
		end
		e_s4 <= e_s3;
		sat_s4 <= sat_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= vld_c[NS];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// ---------------------------------------------------------------
	// divider chain: floor(|n| * 2^15 / e), one quotient bit per cell
	// the partial remainder starts at |n| >> 33; if that is already >= e
	// the quotient would reach 2^48 and the lane overflows
	// ---------------------------------------------------------------
	logic [E_W-1:0] rem [0:DB][0:2];
	logic [DB-1:0] dq [0:DB][0:2];
	logic ovf [0:DB][0:2];
	logic neg [0:DB][0:2];
	logic signed [31:0] vd [0:DB][0:2];
	logic [E_W-1:0] ed [0:DB];
	logic satd [0:DB];
	logic vld_d [0:DB];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rem[0][i] = E_W'(mag_s4[i] >> LOWB);
			dq[0][i] = {mag_s4[i][LOWB-1:0], {QF{1'b0}}};
			ovf[0][i] = E_W'(mag_s4[i] >> LOWB) >= e_s4;
			neg[0][i] = neg_s4[i];
			vd[0][i] = v_s4[i];
		end
		ed[0] = e_s4;
		satd[0] = sat_s4;
		vld_d[0] = vld_s4;
	end

	generate
		for (k = 0; k < DB; k++) begin : g_div
			for (ln = 0; ln < 3; ln++) begin : g_lane
				rvaa_div_cell u_cell (
					.clk(clk),
					.divisor(ed[k]),
					.rem_in(rem[k][ln]),
					.dq_in(dq[k][ln]),
					.rem_q(rem[k+1][ln]),
					.dq_q(dq[k+1][ln])
				);
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		for (int i = 0; i < DB; i++) begin
			for (int j = 0; j < 3; j++) begin
				ovf[i+1][j] <= ovf[i][j];
				neg[i+1][j] <= neg[i][j];
				vd[i+1][j] <= vd[i][j];
			end
			ed[i+1] <= ed[i];
			satd[i+1] <= satd[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= DB; i++) vld_d[i] <= 1'b0;
		end else begin
			for (int i = 0; i < DB; i++) vld_d[i+1] <= vld_d[i];
		end
	end

	// ---------------------------------------------------------------
	// output stage: add the signed increment and clamp to q16.16
	// an overflowed lane takes 2^48, which always clips
	// ---------------------------------------------------------------
	logic signed [O_W-1:0] inc [0:2];
	logic signed [O_W-1:0] osum [0:2];
	logic signed [31:0] ocl [0:2];
	logic clip [0:2];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (ovf[DB][i]) begin
				inc[i] = O_W'(64'sd1 <<< DB);
			end else begin
				inc[i] = signed'(O_W'(dq[DB][i]));
			end
			osum[i] = O_W'(vd[DB][i]) + (neg[DB][i] ? -inc[i] : inc[i]);
			if (osum[i] > O_MAX) begin
				ocl[i] = O_MAX[31:0];
				clip[i] = 1'b1;
			end else if (osum[i] < O_MIN) begin
				ocl[i] = O_MIN[31:0];
				clip[i] = 1'b1;
			end else begin
				ocl[i] = osum[i][31:0];
				clip[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		out_x <= ocl[0];
		out_y <= ocl[1];
		out_z <= ocl[2];
		saturated <= satd[DB] | clip[0] | clip[1] | clip[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_d[DB];
		end
	end

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------

	// every result beat goes back to an accepted beat a fixed latency earlier
	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result beat without a matching accepted beat");

	// the tangent limit leaves a positive cosine term, so e never reaches zero
	a_cos_positive: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (c_s1 > 0))
		else $error("cosine term not positive after tangent limit");

	// lane 0, if it did not overflow, ends with a remainder below the divisor
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_d[DB] && !ovf[DB][0]) |-> (rem[DB][0] < ed[DB]))
		else $error("divider remainder not below divisor");

	// an overflowed quotient must show up as a saturated result
	a_ovf_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_d[DB] && (ovf[DB][0] || ovf[DB][1] || ovf[DB][2])) |=> saturated)
		else $error("quotient overflow without saturated flag");

endmodule
`default_nettype wire
